@@ design/fmr_pkg.sv @@
// Shared types, constants and CRC function for the framed message receiver.
`default_nettype none
package fmr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CRC_W-1:0]  CRC_POLY        = 16'h1021;
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h02;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;

  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CRC_OK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CRC_ERR = 2'd2;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_CRCLO,
    PH_CRCHI
  } phase_t;

  typedef enum logic [2:0] {
    OP_TYPE,
    OP_LEN,
    OP_DATA,
    OP_CRCLO,
    OP_CRCHI
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic [CRC_W-1:0]  crc_received;
    logic [CRC_W-1:0]  crc_computed;
    logic              frame_last;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/framed_message_receiver_crc16.sv @@
// Top level of the framed message receiver with CRC-16 check.
// Accepts one received byte per cycle (in_valid/in_ready) and outputs one
// result per payload byte plus one frame end result that carries the
// received and computed CRC-16 (poly 0x1021, init 0) over type, length and
// payload. A front end hunts the two sync bytes and classifies each byte; a
// four-entry command queue decouples it from the back end, which updates the
// CRC for each byte and holds the result in an output register. The
// sustained rate is one byte per cycle; in_ready drops only when the queue
// fills behind a stalled output. Sync registers are written over the cfg
// channel, which is always ready; index 0 is the first sync byte, index 1
// the second, other indexes are ignored.
`default_nettype none
module framed_message_receiver_crc16 (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [fmr_pkg::BYTE_W-1:0]     rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [fmr_pkg::KIND_W-1:0]          kind,
  output logic [fmr_pkg::BYTE_W-1:0]          frame_type,
  output logic [fmr_pkg::BYTE_W-1:0]          frame_length,
  output logic [fmr_pkg::BYTE_W-1:0]          data_byte,
  output logic [fmr_pkg::BYTE_W-1:0]          byte_index,
  output logic [fmr_pkg::CRC_W-1:0]           crc_received,
  output logic [fmr_pkg::CRC_W-1:0]           crc_computed,
  output logic                                frame_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fmr_pkg::BYTE_W-1:0]     cfg_data
);
  import fmr_pkg::*;

  logic    push, q_full, q_valid, pop;
  cmd_t    push_cmd, q_cmd;
  result_t res;

  fmr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  fmr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  fmr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign kind         = res.kind;
  assign frame_type   = res.frame_type;
  assign frame_length = res.frame_length;
  assign data_byte    = res.data_byte;
  assign byte_index   = res.byte_index;
  assign crc_received = res.crc_received;
  assign crc_computed = res.crc_computed;
  assign frame_last   = res.frame_last;

endmodule
`default_nettype wire

@@ design/fmr_front.sv @@
// Front end: sync hunt, framing state machine and byte classification.
`default_nettype none
module fmr_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [fmr_pkg::BYTE_W-1:0]     rx_byte,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fmr_pkg::BYTE_W-1:0]     cfg_data,
  output logic                                push,
  output fmr_pkg::cmd_t                       push_cmd,
  input  wire logic                           q_full
);
  import fmr_pkg::*;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] remain, remain_next;
  logic [BYTE_W-1:0] sync_first, sync_second;
  logic              take;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SYNC_FIRST) begin
        sync_first <= cfg_data;
      end else if (cfg_index == REG_SYNC_SECOND) begin
        sync_second <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SYNC1;
      remain <= '0;
    end else begin
      phase  <= phase_next;
      remain <= remain_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    remain_next   = remain;
    push          = 1'b0;
    push_cmd.op   = OP_TYPE;
    push_cmd.data = rx_byte;
    if (take) begin
      case (phase)
        PH_SYNC1: begin
          if (rx_byte == sync_first) begin
            phase_next = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_next = (rx_byte == sync_second) ? PH_TYPE : PH_SYNC1;
        end
        PH_TYPE: begin
          push       = 1'b1;
          phase_next = PH_LEN;
        end
        PH_LEN: begin
          push        = 1'b1;
          push_cmd.op = OP_LEN;
          remain_next = rx_byte;
          phase_next  = (rx_byte == '0) ? PH_CRCLO : PH_DATA;
        end
        PH_DATA: begin
          push        = 1'b1;
          push_cmd.op = OP_DATA;
          remain_next = remain - BYTE_W'(1);
          if (remain == BYTE_W'(1)) begin
            phase_next = PH_CRCLO;
          end
        end
        PH_CRCLO: begin
          push        = 1'b1;
          push_cmd.op = OP_CRCLO;
          phase_next  = PH_CRCHI;
        end
        PH_CRCHI: begin
          push        = 1'b1;
          push_cmd.op = OP_CRCHI;
          phase_next  = PH_SYNC1;
        end
        default: begin
          phase_next = PH_SYNC1;
        end
      endcase
    end
  end

  a_data_nonzero_remain: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remain != '0)
    else $error("data phase with no bytes remaining");
  a_sync_no_push: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SYNC1 || phase == PH_SYNC2) |-> !push)
    else $error("sync byte pushed to queue");
  a_len_to_data: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_LEN && rx_byte != '0 |=> phase == PH_DATA)
    else $error("nonzero length did not enter data phase");

endmodule
`default_nettype wire

@@ design/fmr_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none
module fmr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fmr_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               q_valid,
  output fmr_pkg::cmd_t      q_cmd,
  input  wire logic          pop
);
  import fmr_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != QCNT_W'(QDEPTH) |-> (QPTR_W'(wr_ptr - rd_ptr) == count[QPTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

@@ design/fmr_back.sv @@
// Back end: running CRC, frame fields and the registered result stage.
`default_nettype none
module fmr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire fmr_pkg::cmd_t q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fmr_pkg::result_t   res
);
  import fmr_pkg::*;

  logic [BYTE_W-1:0] held_type, held_length, payload_count, crc_low_held;
  logic [CRC_W-1:0]  running_crc, crc_next, rx_crc;
  logic              slot_free, emit;

  assign slot_free = !out_valid || out_ready;
  assign pop       = q_valid && slot_free;
  assign crc_next  = crc_feed((q_cmd.op == OP_TYPE) ? '0 : running_crc, q_cmd.data);
  assign rx_crc    = {q_cmd.data, crc_low_held};
  assign emit      = pop && (q_cmd.op == OP_DATA || q_cmd.op == OP_CRCHI);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_type     <= '0;
      held_length   <= '0;
      payload_count <= '0;
      running_crc   <= '0;
      crc_low_held  <= '0;
    end else if (pop) begin
      case (q_cmd.op)
        OP_TYPE: begin
          held_type   <= q_cmd.data;
          running_crc <= crc_next;
        end
        OP_LEN: begin
          held_length   <= q_cmd.data;
          running_crc   <= crc_next;
          payload_count <= '0;
        end
        OP_DATA: begin
          running_crc   <= crc_next;
          payload_count <= payload_count + BYTE_W'(1);
        end
        OP_CRCLO: begin
          crc_low_held <= q_cmd.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.frame_type   <= held_type;
      res.frame_length <= held_length;
      if (q_cmd.op == OP_DATA) begin
        res.kind         <= KIND_DATA;
        res.data_byte    <= q_cmd.data;
        res.byte_index   <= payload_count;
        res.crc_received <= '0;
        res.crc_computed <= '0;
        res.frame_last   <= 1'b0;
      end else begin
        res.kind         <= (rx_crc == running_crc) ? KIND_CRC_OK : KIND_CRC_ERR;
        res.data_byte    <= '0;
        res.byte_index   <= '0;
        res.crc_received <= rx_crc;
        res.crc_computed <= running_crc;
        res.frame_last   <= 1'b1;
      end
    end
  end

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.frame_last |-> res.kind != KIND_DATA)
    else $error("frame end carries payload kind");
  a_data_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.frame_last |-> res.kind == KIND_DATA && res.crc_computed == '0)
    else $error("payload result with frame end fields");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !pop)
    else $error("queue popped while result stalled");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the framed message receiver: random sync/type/length/CRC-16 byte streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_STALL     = 80;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PHASE_BYTES    = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    kind;
  logic [BYTE_W-1:0]    frame_type;
  logic [BYTE_W-1:0]    frame_length;
  logic [BYTE_W-1:0]    data_byte;
  logic [BYTE_W-1:0]    byte_index;
  logic [CRC_W-1:0]     crc_received;
  logic [CRC_W-1:0]     crc_computed;
  logic                 frame_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  framed_message_receiver_crc16 u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .frame_type   (frame_type),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .crc_received (crc_received),
    .crc_computed (crc_computed),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // deframer model state
  logic [BYTE_W-1:0] sync_a = SYNC_FIRST_RST;
  logic [BYTE_W-1:0] sync_b = SYNC_SECOND_RST;
  phase_t            dphase = PH_SYNC1;
  logic [BYTE_W-1:0] cur_type = '0;
  logic [BYTE_W-1:0] cur_len = '0;
  logic [BYTE_W-1:0] data_cnt = '0;
  logic [CRC_W-1:0]  crc_acc = '0;
  logic [BYTE_W-1:0] crc_lo = '0;

  logic [BYTE_W-1:0] pending_bytes[$];
  result_t           frame_results_due[$];

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   src_gap = 0;
  int   stall_left = 0;
  int   stall_asked = 0;
  int   stall_taken = 0;
  bit   src_calm = 1'b0;
  bit   sink_calm = 1'b0;

  function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] v;
    logic             fb;
    v = c;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = v[CRC_W-1] ^ b[i];
      v = {v[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return v;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic advance_deframer(input logic [BYTE_W-1:0] b);
    result_t          r;
    logic [CRC_W-1:0] rx;
    r = '0;
    case (dphase)
      PH_SYNC1: begin
        if (b == sync_a) dphase = PH_SYNC2;
      end
      PH_SYNC2: begin
        dphase = (b == sync_b) ? PH_TYPE : PH_SYNC1;
      end
      PH_TYPE: begin
        cur_type = b;
        crc_acc = crc16_step('0, b);
        dphase = PH_LEN;
      end
      PH_LEN: begin
        cur_len = b;
        crc_acc = crc16_step(crc_acc, b);
        data_cnt = '0;
        dphase = (b == '0) ? PH_CRCLO : PH_DATA;
      end
      PH_DATA: begin
        crc_acc = crc16_step(crc_acc, b);
        r.kind = KIND_DATA;
        r.frame_type = cur_type;
        r.frame_length = cur_len;
        r.data_byte = b;
        r.byte_index = data_cnt;
        frame_results_due.push_back(r);
        data_cnt = data_cnt + 8'd1;
        if (data_cnt == cur_len) dphase = PH_CRCLO;
      end
      PH_CRCLO: begin
        crc_lo = b;
        dphase = PH_CRCHI;
      end
      PH_CRCHI: begin
        rx = {b, crc_lo};
        r.kind = (rx == crc_acc) ? KIND_CRC_OK : KIND_CRC_ERR;
        r.frame_type = cur_type;
        r.frame_length = cur_len;
        r.crc_received = rx;
        r.crc_computed = crc_acc;
        r.frame_last = 1'b1;
        frame_results_due.push_back(r);
        dphase = PH_SYNC1;
      end
      default: dphase = PH_SYNC1;
    endcase
  endtask

  task automatic check_field(input string name, input logic [CRC_W-1:0] want,
                             input logic [CRC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor, predictor feed and watchdog
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken <= in_valid && in_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SYNC_FIRST) sync_a = cfg_data;
        else if (cfg_index == REG_SYNC_SECOND) sync_b = cfg_data;
      end
      if (in_valid && in_ready) advance_deframer(rx_byte);
      if (out_valid && out_ready) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual kind %0d",
                   $time, kind);
          mismatches++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("kind", CRC_W'(want.kind), CRC_W'(kind));
          check_field("frame_type", CRC_W'(want.frame_type), CRC_W'(frame_type));
          check_field("frame_length", CRC_W'(want.frame_length), CRC_W'(frame_length));
          check_field("data_byte", CRC_W'(want.data_byte), CRC_W'(data_byte));
          check_field("byte_index", CRC_W'(want.byte_index), CRC_W'(byte_index));
          check_field("crc_received", want.crc_received, crc_received);
          check_field("crc_computed", want.crc_computed, crc_computed);
          check_field("frame_last", CRC_W'(want.frame_last), CRC_W'(frame_last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        rx_byte <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        if (!src_calm) src_gap = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_taken != stall_asked) begin
        stall_taken = stall_asked;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!sink_calm) stall_left = idle_len();
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_frame(input logic [BYTE_W-1:0] typ, input int plen, input bit bad);
    logic [CRC_W-1:0]  c;
    logic [BYTE_W-1:0] p;
    pending_bytes.push_back(sync_a);
    pending_bytes.push_back(sync_b);
    pending_bytes.push_back(typ);
    pending_bytes.push_back(plen[BYTE_W-1:0]);
    c = crc16_step(crc16_step('0, typ), plen[BYTE_W-1:0]);
    for (int i = 0; i < plen; i++) begin
      p = 8'($urandom);
      pending_bytes.push_back(p);
      c = crc16_step(c, p);
    end
    if (bad) c = c ^ 16'($urandom_range(1, 16'hFFFF));
    pending_bytes.push_back(c[7:0]);
    pending_bytes.push_back(c[15:8]);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || frame_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] s;
    int r;
    int plen;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: byte extremes, wrong second sync, zero length, good and bad CRC
    src_calm = 1'b1;
    sink_calm = 1'b1;
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(SYNC_FIRST_RST);
    pending_bytes.push_back(SYNC_FIRST_RST);
    pending_bytes.push_back(SYNC_FIRST_RST);
    pending_bytes.push_back(8'h03);
    push_frame(8'h00, 0, 1'b0);
    push_frame(8'hFF, 2, 1'b0);
    push_frame(8'($urandom), 1, 1'b1);
    wait_quiet();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_SYNC_FIRST, 8'h00);
          write_reg(REG_SYNC_SECOND, 8'hFF);
          write_reg(REG_SPARE_2, 8'hFF);
          write_reg(REG_SPARE_3, 8'h00);
        end
        2: begin
          write_reg(REG_SYNC_FIRST, 8'hFF);
          write_reg(REG_SYNC_SECOND, 8'h00);
          write_reg(REG_SPARE_2, 8'h00);
          write_reg(REG_SPARE_3, 8'hFF);
        end
        3: begin
          s = 8'($urandom);
          write_reg(REG_SYNC_FIRST, s);
          write_reg(REG_SYNC_SECOND, s);
        end
        default: begin
          write_reg(REG_SYNC_FIRST, 8'($urandom));
          write_reg(REG_SYNC_SECOND, 8'($urandom));
        end
      endcase

      if (ph == 4) begin
        // back-pressure: sink holds off while a full-length frame streams in
        src_calm = 1'b1;
        sink_calm = 1'b0;
        stall_asked++;
        push_frame(8'($urandom), 255, 1'b0);
        push_frame(8'($urandom), 0, 1'b0);
      end else begin
        src_calm = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
        while (pending_bytes.size() < PHASE_BYTES) begin
          r = $urandom_range(0, 99);
          if (r < 65) begin
            plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            push_frame(8'($urandom), plen, 1'b0);
          end else if (r < 75) begin
            push_frame(8'($urandom), $urandom_range(0, 12), 1'b1);
          end else if (r < 85) begin
            repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
          end else if (r < 93) begin
            pending_bytes.push_back(sync_a);
            pending_bytes.push_back(8'($urandom));
          end else begin
            // frame cut short; following bytes get absorbed into it
            plen = $urandom_range(4, 12);
            pending_bytes.push_back(sync_a);
            pending_bytes.push_back(sync_b);
            pending_bytes.push_back(8'($urandom));
            pending_bytes.push_back(plen[BYTE_W-1:0]);
            repeat ($urandom_range(0, 3)) pending_bytes.push_back(8'($urandom));
          end
        end
      end
      wait_quiet();
    end

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
